/* rtl/core/skqt_pkg.sv */
package skqt_pkg;

  localparam int CAPACITY = 64;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int ID_W     = 32;

  typedef enum logic [1:0] {
    REQ_INSERT      = 2'd0,
    REQ_DELETE      = 2'd1,
    REQ_KEY_SEARCH  = 2'd2,
    REQ_RANK_SEARCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_MATCH = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DELETE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key_in;
    logic [ID_W-1:0]  id_in;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic ge_lo;
    logic le_hi;
  } cell_flags_t;

endpackage

/* rtl/core/skqt_cell.sv */
module skqt_cell (
  input  logic                      clk,
  input  skqt_pkg::cell_ctrl_t      ctrl,
  input  logic                      valid,
  input  logic                      left_lt,
  input  logic [skqt_pkg::KEY_W-1:0] left_key,
  input  logic [skqt_pkg::ID_W-1:0]  left_id,
  input  logic [skqt_pkg::KEY_W-1:0] right_key,
  input  logic [skqt_pkg::ID_W-1:0]  right_id,
  output logic [skqt_pkg::KEY_W-1:0] key,
  output logic [skqt_pkg::ID_W-1:0]  id,
  output skqt_pkg::cell_flags_t     flags
);

  logic [skqt_pkg::KEY_W-1:0] key_next;
  logic [skqt_pkg::ID_W-1:0]  id_next;

  always_comb begin
    flags.lt    = valid && (key < ctrl.key_in);
    flags.eq    = valid && (key == ctrl.key_in);
    flags.ge_lo = key >= ctrl.lo;
    flags.le_hi = key <= ctrl.hi;
  end

  always_comb begin
    key_next = key;
    id_next  = id;
    case (ctrl.op)
      skqt_pkg::CELL_INSERT: begin
        if (!flags.lt) begin
          if (left_lt) begin
            key_next = ctrl.key_in;
            id_next  = ctrl.id_in;
          end else begin
            key_next = left_key;
            id_next  = left_id;
          end
        end
      end
      skqt_pkg::CELL_SHIFT: begin
        // at or past the start of the deleted run
        if (flags.ge_lo) begin
          key_next = right_key;
          id_next  = right_id;
        end
      end
      skqt_pkg::CELL_ROTATE: begin
        key_next = right_key;
        id_next  = right_id;
      end
      default: begin
        key_next = key;
        id_next  = id;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    id  <= id_next;
  end

endmodule

/* rtl/core/sorted_key_table_range_query_unit.sv */
// Ordered table of up to CAPACITY unique (key, id) pairs held in a row of cells, entry i in
// cell i, kept in ascending key order. One request is handled at a time. A range delete
// removes one entry per step until none is left in range; a key or rank search makes one
// full rotation of the cell ring, which brings every entry past the head cell in key order
// and leaves the table as it was; output backpressure can stall a request. Every request
// ends with one result marked by tlast; a search emits one result per matching entry, or a
// single done result.
module sorted_key_table_range_query_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // key_low, key_high, new_order_id
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_id
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last_result
);

  localparam int N  = skqt_pkg::CAPACITY;
  localparam int CW = skqt_pkg::COUNT_W;
  localparam int KW = skqt_pkg::KEY_W;
  localparam int IW = skqt_pkg::ID_W;

  skqt_pkg::state_t   state, state_next;
  skqt_pkg::req_t     req_type;
  skqt_pkg::status_t  fin_status, fin_val, push_status;
  skqt_pkg::cell_op_t op;
  skqt_pkg::cell_ctrl_t ctrl;

  logic [KW-1:0] key_low, key_high;
  logic [IW-1:0] new_order_id;
  logic [CW-1:0] count, step;
  logic          pend_valid;
  logic [IW-1:0] pend_id;

  logic [KW-1:0] cell_key [N];
  logic [IW-1:0] cell_id  [N];
  skqt_pkg::cell_flags_t cell_flags [N];
  logic [N-1:0]  valid_vec, lt_vec, eq_vec, del_vec;

  logic          can_push, dup, full, any_del, head_valid, key_hit, rank_hit, hit, scan_done;
  logic [31:0]   rank;
  logic          accept, push, push_last, step_adv, pend_load, fin_set, cnt_inc, cnt_dec;
  logic [IW-1:0] push_id;

  assign ctrl.op     = op;
  assign ctrl.key_in = key_low;
  assign ctrl.id_in  = new_order_id;
  assign ctrl.lo     = key_low;
  assign ctrl.hi     = key_high;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign valid_vec[i] = CW'(i) < count;
    assign lt_vec[i]    = cell_flags[i].lt;
    assign eq_vec[i]    = cell_flags[i].eq;
    assign del_vec[i]   = valid_vec[i] && cell_flags[i].ge_lo && cell_flags[i].le_hi;

    if (i == 0) begin : g_head
      skqt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid_vec[i]),
        .left_lt   (1'b1),
        .left_key  (key_low),
        .left_id   (new_order_id),
        .right_key (cell_key[i+1]),
        .right_id  (cell_id[i+1]),
        .key       (cell_key[i]),
        .id        (cell_id[i]),
        .flags     (cell_flags[i])
      );
    end else if (i == N - 1) begin : g_tail
      skqt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid_vec[i]),
        .left_lt   (lt_vec[i-1]),
        .left_key  (cell_key[i-1]),
        .left_id   (cell_id[i-1]),
        .right_key (cell_key[0]),
        .right_id  (cell_id[0]),
        .key       (cell_key[i]),
        .id        (cell_id[i]),
        .flags     (cell_flags[i])
      );
    end else begin : g_mid
      skqt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid_vec[i]),
        .left_lt   (lt_vec[i-1]),
        .left_key  (cell_key[i-1]),
        .left_id   (cell_id[i-1]),
        .right_key (cell_key[i+1]),
        .right_id  (cell_id[i+1]),
        .key       (cell_key[i]),
        .id        (cell_id[i]),
        .flags     (cell_flags[i])
      );
    end
  end

  assign can_push   = !m_axis_tvalid || m_axis_tready;
  assign dup        = |eq_vec;
  assign full       = count == CW'(N);
  assign any_del    = |del_vec;
  assign head_valid = step < count;
  assign key_hit    = head_valid && cell_flags[0].ge_lo && cell_flags[0].le_hi;
  assign rank       = {{(32-CW){1'b0}}, step} + 32'd1;
  assign rank_hit   = head_valid && (rank >= key_low) && (rank <= key_high);
  assign hit        = (req_type == skqt_pkg::REQ_RANK_SEARCH) ? rank_hit : key_hit;
  assign scan_done  = step == CW'(N);
  assign accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      skqt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (skqt_pkg::req_t'(s_axis_tuser))
            skqt_pkg::REQ_INSERT: state_next = skqt_pkg::ST_INSERT;
            skqt_pkg::REQ_DELETE: state_next = skqt_pkg::ST_DELETE;
            default:              state_next = skqt_pkg::ST_SCAN;
          endcase
        end
      end
      skqt_pkg::ST_INSERT: state_next = skqt_pkg::ST_FINISH;
      skqt_pkg::ST_DELETE: begin
        if (!any_del) state_next = skqt_pkg::ST_FINISH;
      end
      skqt_pkg::ST_SCAN: begin
        if (scan_done) state_next = skqt_pkg::ST_FINISH;
      end
      skqt_pkg::ST_FINISH: begin
        if (can_push) state_next = skqt_pkg::ST_IDLE;
      end
      default: state_next = skqt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    op            = skqt_pkg::CELL_HOLD;
    push          = 1'b0;
    push_id       = '0;
    push_status   = skqt_pkg::STAT_DONE;
    push_last     = 1'b0;
    step_adv      = 1'b0;
    pend_load     = 1'b0;
    fin_set       = 1'b0;
    fin_val       = skqt_pkg::STAT_DONE;
    cnt_inc       = 1'b0;
    cnt_dec       = 1'b0;
    case (state)
      skqt_pkg::ST_IDLE: s_axis_tready = 1'b1;
      skqt_pkg::ST_INSERT: begin
        fin_set = 1'b1;
        if (dup) begin
          fin_val = skqt_pkg::STAT_DUP;
        end else if (full) begin
          fin_val = skqt_pkg::STAT_FULL;
        end else begin
          op      = skqt_pkg::CELL_INSERT;
          cnt_inc = 1'b1;
        end
      end
      skqt_pkg::ST_DELETE: begin
        if (any_del) begin
          op      = skqt_pkg::CELL_SHIFT;
          cnt_dec = 1'b1;
        end
      end
      skqt_pkg::ST_SCAN: begin
        // hold one match back so the final one can carry tlast
        if (!scan_done && (!(hit && pend_valid) || can_push)) begin
          op       = skqt_pkg::CELL_ROTATE;
          step_adv = 1'b1;
          if (hit) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              push        = 1'b1;
              push_id     = pend_id;
              push_status = skqt_pkg::STAT_MATCH;
            end
          end
        end
      end
      skqt_pkg::ST_FINISH: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (pend_valid) begin
            push_id     = pend_id;
            push_status = skqt_pkg::STAT_MATCH;
          end else begin
            push_status = fin_status;
          end
        end
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= skqt_pkg::ST_IDLE;
      count         <= '0;
      step          <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) begin
        count <= count + CW'(1);
      end else if (cnt_dec) begin
        count <= count - CW'(1);
      end
      if (accept) begin
        step       <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (step_adv) step <= step + CW'(1);
        if (pend_load) pend_valid <= 1'b1;
      end
      if (push) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type     <= skqt_pkg::req_t'(s_axis_tuser);
      key_low      <= s_axis_tdata[31:0];
      key_high     <= s_axis_tdata[63:32];
      new_order_id <= s_axis_tdata[95:64];
      fin_status   <= skqt_pkg::STAT_DONE;
    end else if (fin_set) begin
      fin_status <= fin_val;
    end
    if (pend_load) pend_id <= cell_id[0];
    if (push) begin
      m_axis_tdata <= push_id;
      m_axis_tuser <= push_status;
      m_axis_tlast <= push_last;
    end
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  import skqt_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 30;
  localparam int QUIET_TAIL   = 20;

  typedef struct {
    req_t        kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] id;
    bit          wait_idle;
  } request_s;

  typedef struct {
    logic [31:0] id;
    status_t     status;
    logic        is_last;
  } result_s;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sorted_key_table_range_query_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow copy of the ordered table
  logic [31:0] row_key [CAPACITY];
  logic [31:0] row_id  [CAPACITY];
  int          row_count = 0;

  request_s request_queue[$];
  result_s  awaited_results[$];
  request_s cur_request;

  int    n_predicted = 0;
  int    n_seen = 0;
  int    n_accepted = 0;
  int    req_next = 0;
  int    errors = 0;
  int    cycles = 0;
  int    src_gap = 0;
  int    sink_gap = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  bit    sink_calm = 1'b0;
  bit    quiet = 1'b0;
  bit    stim_done = 1'b0;
  bit    launch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic add_request(input req_t kind, input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] id, input bit wait_idle);
    request_s r;
    r.kind = kind;
    r.lo = lo;
    r.hi = hi;
    r.id = id;
    r.wait_idle = wait_idle;
    request_queue = {request_queue, r};
  endtask

  // apply one request to the shadow table and queue the results it causes
  task automatic table_apply(input request_s r);
    result_s res[$];
    result_s one;
    int pos;
    int w;
    int i;
    longint unsigned rlo;
    longint unsigned rhi;
    longint unsigned k;
    one.id = '0;
    one.status = STAT_DONE;
    one.is_last = 1'b0;
    case (r.kind)
      REQ_INSERT: begin
        pos = 0;
        while (pos < row_count && row_key[pos] < r.lo) pos++;
        if (pos < row_count && row_key[pos] == r.lo) begin
          one.status = STAT_DUP;
        end else if (row_count >= CAPACITY) begin
          one.status = STAT_FULL;
        end else begin
          for (i = row_count; i > pos; i--) begin
            row_key[i] = row_key[i-1];
            row_id[i] = row_id[i-1];
          end
          row_key[pos] = r.lo;
          row_id[pos] = r.id;
          row_count++;
        end
        res = {res, one};
      end
      REQ_DELETE: begin
        w = 0;
        for (i = 0; i < row_count; i++) begin
          if (!(row_key[i] >= r.lo && row_key[i] <= r.hi)) begin
            row_key[w] = row_key[i];
            row_id[w] = row_id[i];
            w++;
          end
        end
        row_count = w;
        res = {res, one};
      end
      REQ_KEY_SEARCH: begin
        one.status = STAT_MATCH;
        for (i = 0; i < row_count; i++) begin
          if (row_key[i] >= r.lo && row_key[i] <= r.hi) begin
            one.id = row_id[i];
            res = {res, one};
          end
        end
      end
      default: begin
        one.status = STAT_MATCH;
        rlo = (r.lo == 0) ? 1 : r.lo;
        rhi = (r.hi > row_count) ? row_count : r.hi;
        for (k = rlo; k <= rhi; k++) begin
          one.id = row_id[k-1];
          res = {res, one};
        end
      end
    endcase
    if (res.size() == 0) begin
      one.id = '0;
      one.status = STAT_DONE;
      res = {res, one};
    end
    res[res.size()-1].is_last = 1'b1;
    awaited_results = {awaited_results, res};
    n_predicted <= n_predicted + res.size();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      launch = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        table_apply(cur_request);
        n_accepted <= n_accepted + 1;
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 14);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (request_queue.size() > req_next) begin
          if (!request_queue[req_next].wait_idle ||
              (!s_axis_tvalid && n_seen == n_predicted))
            launch = 1'b1;
        end
        if (launch) begin
          cur_request = request_queue[req_next];
          req_next++;
          s_axis_tdata <= {cur_request.id, cur_request.hi, cur_request.lo};
          s_axis_tuser <= cur_request.kind;
        end
        s_axis_tvalid <= launch;
      end
      quiet <= (request_queue.size() - req_next) <= QUIET_TAIL;
      stim_done <= request_queue.size() == req_next && !launch &&
                   !(s_axis_tvalid && !s_axis_tready);
    end
  end

  // long output hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted == HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
      if (sink_gap > 0) sink_gap--;
      else if (!quiet && !sink_calm && $urandom_range(0, 99) < 12)
        sink_gap = $urandom_range(1, 14);
      m_axis_tready <= (sink_gap == 0) && (hold_left == 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_s e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (n_seen >= awaited_results.size()) begin
        $display("%0t: unexpected result: expected none, actual id=%h status=%0d last=%0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        e = awaited_results[n_seen];
        n_seen <= n_seen + 1;
        if (m_axis_tdata !== e.id || m_axis_tuser !== e.status ||
            m_axis_tlast !== e.is_last) begin
          $display("%0t: result mismatch: expected id=%h status=%0d last=%0b, %s",
                   $time, e.id, e.status, e.is_last,
                   $sformatf("actual id=%h status=%0d last=%0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] fill_key [CAPACITY];
    logic [31:0] t;
    int i;
    int j;
    int pick;
    logic [31:0] lo;

    // directed requests
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_RANK_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_DELETE, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_INSERT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
    add_request(REQ_INSERT, 32'd100, $urandom, $urandom, 1'b0);
    add_request(REQ_INSERT, 32'd50, $urandom, $urandom, 1'b0);
    add_request(REQ_INSERT, 32'd100, $urandom, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'd60, 32'd40, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'd50, 32'd100, $urandom, 1'b0);
    add_request(REQ_RANK_SEARCH, 32'd0, 32'd2, $urandom, 1'b0);
    add_request(REQ_RANK_SEARCH, 32'd3, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_RANK_SEARCH, 32'd4, 32'd2, $urandom, 1'b0);
    add_request(REQ_RANK_SEARCH, 32'd5, 32'd5, $urandom, 1'b0);
    add_request(REQ_DELETE, 32'd200, 32'd100, $urandom, 1'b0);
    add_request(REQ_DELETE, 32'd50, 32'd100, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_DELETE, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_INSERT, 32'd7, $urandom, $urandom, 1'b1);

    // fill the table in random order until it is full
    for (i = 0; i < CAPACITY; i++) fill_key[i] = 32'd1000 + i * 4 + $urandom_range(0, 3);
    for (i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = fill_key[i];
      fill_key[i] = fill_key[j];
      fill_key[j] = t;
    end
    for (i = 0; i < CAPACITY; i++) add_request(REQ_INSERT, fill_key[i], $urandom, $urandom, 1'b0);
    for (i = 0; i < 4; i++) begin
      pick = $urandom_range(0, CAPACITY - 1);
      if (i % 2 == 0) add_request(REQ_INSERT, fill_key[pick], $urandom, $urandom, 1'b0);
      else add_request(REQ_INSERT, $urandom_range(1300, 2000), $urandom, $urandom, 1'b0);
    end
    add_request(REQ_RANK_SEARCH, 32'd0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b1);

    // mixed traffic around the populated key range
    for (i = 0; i < 20; i++) begin
      pick = $urandom_range(0, 3);
      lo = $urandom_range(980, 1300);
      case (pick)
        0: begin
          if ($urandom_range(0, 9) == 0) lo = $urandom;
          add_request(REQ_INSERT, lo, $urandom, $urandom, $urandom_range(0, 9) == 0);
        end
        1: begin
          if ($urandom_range(0, 7) == 0)
            add_request(REQ_DELETE, lo, lo - $urandom_range(1, 20), $urandom, 1'b0);
          else
            add_request(REQ_DELETE, lo, lo + $urandom_range(0, 12), $urandom,
                        $urandom_range(0, 9) == 0);
        end
        2: begin
          if ($urandom_range(0, 9) == 0)
            add_request(REQ_KEY_SEARCH, $urandom, $urandom, $urandom, 1'b0);
          else
            add_request(REQ_KEY_SEARCH, lo - 80, lo + $urandom_range(0, 80), $urandom,
                        $urandom_range(0, 9) == 0);
        end
        default: begin
          lo = $urandom_range(0, 70);
          if ($urandom_range(0, 7) == 0)
            add_request(REQ_RANK_SEARCH, $urandom, $urandom, $urandom, 1'b0);
          else if ($urandom_range(0, 4) == 0)
            add_request(REQ_RANK_SEARCH, lo, 32'hFFFF_FFFF, $urandom, 1'b0);
          else
            add_request(REQ_RANK_SEARCH, lo, lo + $urandom_range(0, 20), $urandom,
                        $urandom_range(0, 9) == 0);
        end
      endcase
    end
    add_request(REQ_DELETE, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_request(REQ_KEY_SEARCH, 32'h0, 32'hFFFF_FFFF, $urandom, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!(stim_done && n_seen == n_predicted));
    repeat (CAPACITY + 20) @(posedge clk);
    @(negedge clk);
    if (awaited_results.size() != n_seen) begin
      $display("%0t: %0d expected results never arrived", $time,
               awaited_results.size() - n_seen);
    end
    if (errors == 0 && awaited_results.size() == n_seen) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
